// ===== rtl/camera_primary_ray_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the primary ray generator
// Clocked concurrent checks, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef CAMERA_PRIMARY_RAY_MACROS_SVH
`define CAMERA_PRIMARY_RAY_MACROS_SVH

// check that holds while out of reset
`define CPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that must also hold across the reset edge
`define CPR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Constants and register codes of the pinhole camera primary ray generator.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PITCH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd7;

    localparam logic [63:0] HALF_SIZES_RST  = 64'h0001_0000_0001_0000;
    localparam logic [31:0] PIXEL_PITCH_RST = 32'h0080_0000;
    localparam logic [63:0] ROW0_COLS01_RST = 64'h0001_0000_0000_0000;
    localparam logic [63:0] ROW1_COLS01_RST = 64'h0000_0000_0001_0000;
    localparam logic [63:0] ROW2_COLS01_RST = 64'h0000_0000_0000_0000;
    localparam logic [63:0] ROW0_COLS23_RST = 64'h0000_0000_0000_0000;
    localparam logic [63:0] ROW1_COLS23_RST = 64'h0000_0000_0000_0000;
    localparam logic [63:0] ROW2_COLS23_RST = 64'h0001_0000_0000_0000;

    localparam int LANES  = 3;
    localparam int MAG_W  = 30;   // normalized magnitude
    localparam int SQ_W   = 60;
    localparam int SUM_W  = 62;   // sum of squares
    localparam int ROOT_W = 31;   // floor(sqrt(sum))
    localparam int SREM_W = 33;
    localparam int QUO_W  = 31;   // quotient bits per lane
    localparam int NUM_W  = 61;   // mag*2^30 + len/2
    localparam int DMAG_W = 63;   // magnitude before normalization

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [QUO_W-1:0]  quo_t;

endpackage

// ===== rtl/camera_primary_ray.sv =====
// Throughput: one ray per cycle; the square root and the three dividers are
// unrolled one result bit per stage, so every stage takes a new pixel.
// A stall on the output holds the whole pipeline; no transaction is lost.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// identity view matrix, half sizes of 1.0 and a pixel pitch of 2^-7.
// ----------------------------------------------------------------------------
// camera_primary_ray
// Pinhole camera primary ray generator: pixel pair in, origin and unit
// direction out, through a fixed-point inverse view matrix.
// ----------------------------------------------------------------------------
`include "camera_primary_ray_macros.svh"

module camera_primary_ray #(
    parameter int COORD_BITS = 12
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // pixel_x, pixel_y (COORD_BITS each), zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    output logic [191:0]                             m_tdata,
    input  logic                                     cfg_wr_en,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [cpr_pkg::CFG_W-1:0]                cfg_wdata
);

    localparam int CB      = COORD_BITS;
    localparam int OFF_W   = CB + 33;
    localparam int OFFQ_W  = CB + 19;
    localparam int WD_W    = ((OFFQ_W > 32) ? OFFQ_W : 32) + 2;
    localparam int L       = cpr_pkg::LANES;

    localparam logic signed [WD_W-1:0] W_MAX = {{(WD_W-32){1'b0}}, 32'hFFFF_FFFF};
    localparam logic signed [WD_W-1:0] W_MIN = -W_MAX;

    // ---------------- configuration ----------------
    logic [63:0] half_sizes_reg;
    logic [31:0] pixel_pitch_reg;
    logic [63:0] mat01_reg [0:L-1];
    logic [63:0] mat23_reg [0:L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_sizes_reg  <= cpr_pkg::HALF_SIZES_RST;
            pixel_pitch_reg <= cpr_pkg::PIXEL_PITCH_RST;
            mat01_reg[0]    <= cpr_pkg::ROW0_COLS01_RST;
            mat01_reg[1]    <= cpr_pkg::ROW1_COLS01_RST;
            mat01_reg[2]    <= cpr_pkg::ROW2_COLS01_RST;
            mat23_reg[0]    <= cpr_pkg::ROW0_COLS23_RST;
            mat23_reg[1]    <= cpr_pkg::ROW1_COLS23_RST;
            mat23_reg[2]    <= cpr_pkg::ROW2_COLS23_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cpr_pkg::REG_HALF_SIZES:  half_sizes_reg  <= cfg_wdata;
                cpr_pkg::REG_PIXEL_PITCH: pixel_pitch_reg <= cfg_wdata[31:0];
                cpr_pkg::REG_ROW0_COLS01: mat01_reg[0]    <= cfg_wdata;
                cpr_pkg::REG_ROW0_COLS23: mat23_reg[0]    <= cfg_wdata;
                cpr_pkg::REG_ROW1_COLS01: mat01_reg[1]    <= cfg_wdata;
                cpr_pkg::REG_ROW1_COLS23: mat23_reg[1]    <= cfg_wdata;
                cpr_pkg::REG_ROW2_COLS01: mat01_reg[2]    <= cfg_wdata;
                cpr_pkg::REG_ROW2_COLS23: mat23_reg[2]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // round the offset to Q16.16, subtract from the half size, saturate
    function automatic logic signed [32:0] plane(input logic [OFF_W-1:0] off,
                                                 input logic [31:0] half);
        logic [OFF_W:0]          rsum;
        logic [OFFQ_W-1:0]       offq;
        logic signed [WD_W-1:0]  w;
        rsum = {1'b0, off} + (OFF_W+1)'(16384);
        offq = rsum[OFF_W:15];
        w    = $signed(WD_W'(half)) - $signed(WD_W'(offq));
        if (w > W_MAX) begin
            w = W_MAX;
        end else if (w < W_MIN) begin
            w = W_MIN;
        end
        return w[32:0];
    endfunction

    // ---------------- S1: pixel offsets ----------------
    logic             v1_reg;
    logic [OFF_W-1:0] offx_reg, offy_reg;
    logic [CB:0]      odd_x, odd_y;
    assign odd_x = {s_tdata[CB-1:0], 1'b1};
    assign odd_y = {s_tdata[2*CB-1:CB], 1'b1};

    // ---------------- S2: plane point ----------------
    logic                v2_reg;
    logic signed [32:0]  wx_reg, wy_reg;

    // ---------------- S3: products ----------------
    logic                v3_reg;
    logic signed [62:0]  t0_reg [0:L-1];
    logic signed [62:0]  t1_reg [0:L-1];

    // ---------------- S4: direction sum ----------------
    logic                v4_reg;
    logic signed [63:0]  d_reg [0:L-1];

    // ---------------- S5: sign / magnitude ----------------
    logic                         v5_reg;
    logic [cpr_pkg::DMAG_W-1:0]   mag5_reg [0:L-1];
    logic [L-1:0]                 neg5_reg;

    // ---------------- S6: shift amount ----------------
    logic                         v6_reg, zero6_reg, right6_reg;
    logic [5:0]                   amt6_reg;
    logic [cpr_pkg::DMAG_W-1:0]   mag6_reg [0:L-1];
    logic [L-1:0]                 neg6_reg;
    logic [cpr_pkg::DMAG_W-1:0]   mag_or;
    logic [5:0]                   bl_next;

    // ---------------- S7: normalized ----------------
    logic                 v7_reg, zero7_reg;
    cpr_pkg::mag_t        mag7_reg [0:L-1];
    logic [L-1:0]         neg7_reg;
    cpr_pkg::mag_t        norm_or;

    // ---------------- S8: squares ----------------
    logic                       v8_reg, zero8_reg;
    logic [cpr_pkg::SQ_W-1:0]   sq8_reg [0:L-1];
    cpr_pkg::mag_t              mag8_reg [0:L-1];
    logic [L-1:0]               neg8_reg;

    // ---------------- square root, one bit per stage ----------------
    localparam int RS = cpr_pkg::ROOT_W;
    logic                          sv_reg   [0:RS];
    logic                          sz_reg   [0:RS];
    logic [cpr_pkg::SUM_W-1:0]     ssum_reg [0:RS];
    cpr_pkg::root_t                sroot_reg[0:RS];
    logic [cpr_pkg::SREM_W-1:0]    srem_reg [0:RS];
    cpr_pkg::mag_t                 smag_reg [0:RS][0:L-1];
    logic [L-1:0]                  sneg_reg [0:RS];

    // ---------------- division, one quotient bit per stage ----------------
    localparam int QS = cpr_pkg::QUO_W;
    logic                          dv_reg   [0:QS];
    logic                          dz_reg   [0:QS];
    cpr_pkg::root_t                dlen_reg [0:QS];
    cpr_pkg::num_t                 dnum_reg [0:QS][0:L-1];
    logic [QS-1:0]                 drem_reg [0:QS][0:L-1];
    cpr_pkg::quo_t                 dq_reg   [0:QS][0:L-1];
    logic [L-1:0]                  dneg_reg [0:QS];

    // ---------------- front stages ----------------
    always_comb begin
        mag_or  = mag5_reg[0] | mag5_reg[1] | mag5_reg[2];
        bl_next = '0;
        for (int i = 0; i < cpr_pkg::DMAG_W; i++) begin
            if (mag_or[i]) begin
                bl_next = 6'(i + 1);
            end
        end
    end

    assign norm_or = mag7_reg[0] | mag7_reg[1] | mag7_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            offx_reg <= OFF_W'(odd_x) * OFF_W'(pixel_pitch_reg);
            offy_reg <= OFF_W'(odd_y) * OFF_W'(pixel_pitch_reg);

            wx_reg <= plane(offx_reg, half_sizes_reg[63:32]);
            wy_reg <= plane(offy_reg, half_sizes_reg[31:0]);

            for (int r = 0; r < L; r++) begin
                logic signed [64:0] p0;
                logic signed [64:0] p1;
                logic signed [63:0] zt;
                p0 = 65'($signed(mat01_reg[r][63:32])) * 65'(wx_reg);
                p1 = 65'($signed(mat01_reg[r][31:0])) * 65'(wy_reg);
                t0_reg[r] <= p0[64:2];
                t1_reg[r] <= p1[64:2];

                // camera plane sits at z = -1
                zt = 64'($signed(mat23_reg[r][63:32])) <<< 14;
                d_reg[r] <= 64'(t0_reg[r]) + 64'(t1_reg[r]) - zt;

                neg5_reg[r] <= d_reg[r][63];
                mag5_reg[r] <= d_reg[r][63] ? 63'(~d_reg[r] + 64'd1) : d_reg[r][62:0];

                mag6_reg[r] <= mag5_reg[r];
                neg6_reg[r] <= neg5_reg[r];

                mag7_reg[r] <= right6_reg ? cpr_pkg::MAG_W'(mag6_reg[r] >> amt6_reg)
                                          : cpr_pkg::MAG_W'(mag6_reg[r] << amt6_reg);
                neg7_reg[r] <= neg6_reg[r];

                sq8_reg[r]  <= cpr_pkg::SQ_W'(mag7_reg[r]) * cpr_pkg::SQ_W'(mag7_reg[r]);
                mag8_reg[r] <= mag7_reg[r];
                neg8_reg[r] <= neg7_reg[r];
            end

            zero6_reg  <= (mag_or == '0);
            right6_reg <= (bl_next > 6'd30);
            amt6_reg   <= (bl_next > 6'd30) ? (bl_next - 6'd30) : (6'd30 - bl_next);
            zero7_reg  <= zero6_reg;
            zero8_reg  <= zero7_reg;
        end
    end

    // ---------------- square root ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            sv_reg[0] <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sz_reg[0]    <= zero8_reg;
            ssum_reg[0]  <= cpr_pkg::SUM_W'(sq8_reg[0]) + cpr_pkg::SUM_W'(sq8_reg[1])
                          + cpr_pkg::SUM_W'(sq8_reg[2]);
            sroot_reg[0] <= '0;
            srem_reg[0]  <= '0;
            sneg_reg[0]  <= neg8_reg;
            for (int r = 0; r < L; r++) begin
                smag_reg[0][r] <= mag8_reg[r];
            end
        end
    end

    for (genvar k = 0; k < RS; k++) begin : g_sqrt
        localparam int B = RS - 1 - k;
        logic [cpr_pkg::SREM_W+1:0] s_try;
        logic [cpr_pkg::SREM_W+1:0] s_trial;
        logic                       s_ge;
        assign s_try   = {srem_reg[k], ssum_reg[k][2*B+1 -: 2]};
        assign s_trial = (cpr_pkg::SREM_W+2)'({sroot_reg[k], 2'b01});
        assign s_ge    = (s_try >= s_trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k+1] <= 1'b0;
            end else if (en) begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sz_reg[k+1]    <= sz_reg[k];
                ssum_reg[k+1]  <= ssum_reg[k];
                sroot_reg[k+1] <= {sroot_reg[k][RS-2:0], s_ge};
                srem_reg[k+1]  <= s_ge ? cpr_pkg::SREM_W'(s_try - s_trial)
                                       : cpr_pkg::SREM_W'(s_try);
                sneg_reg[k+1]  <= sneg_reg[k];
                for (int r = 0; r < L; r++) begin
                    smag_reg[k+1][r] <= smag_reg[k][r];
                end
            end
        end
    end

    // ---------------- division ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= sv_reg[RS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dz_reg[0]   <= sz_reg[RS];
            dlen_reg[0] <= sroot_reg[RS];
            dneg_reg[0] <= sneg_reg[RS];
            for (int r = 0; r < L; r++) begin
                cpr_pkg::num_t n;
                n = cpr_pkg::NUM_W'({smag_reg[RS][r], 30'd0})
                  + cpr_pkg::NUM_W'(sroot_reg[RS][RS-1:1]);
                dnum_reg[0][r] <= n;
                drem_reg[0][r] <= QS'(n[cpr_pkg::NUM_W-1:QS]);
                dq_reg[0][r]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < QS; j++) begin : g_div
        localparam int B = QS - 1 - j;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dz_reg[j+1]   <= dz_reg[j];
                dlen_reg[j+1] <= dlen_reg[j];
                dneg_reg[j+1] <= dneg_reg[j];
                for (int r = 0; r < L; r++) begin
                    logic [QS:0] d_try;
                    logic [QS:0] d_len;
                    logic        d_ge;
                    d_try = {drem_reg[j][r], dnum_reg[j][r][B]};
                    d_len = {1'b0, dlen_reg[j]};
                    d_ge  = (d_try >= d_len);
                    dnum_reg[j+1][r] <= dnum_reg[j][r];
                    drem_reg[j+1][r] <= d_ge ? QS'(d_try - d_len) : d_try[QS-1:0];
                    dq_reg[j+1][r]   <= {dq_reg[j][r][QS-2:0], d_ge};
                end
            end
        end
    end

    // ---------------- output register ----------------
    logic [31:0] dir_next [0:L-1];
    always_comb begin
        for (int r = 0; r < L; r++) begin
            if (dz_reg[QS]) begin
                dir_next[r] = '0;
            end else if (dneg_reg[QS][r]) begin
                dir_next[r] = 32'd0 - 32'(dq_reg[QS][r]);
            end else begin
                dir_next[r] = 32'(dq_reg[QS][r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_reg[QS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {dir_next[2], dir_next[1], dir_next[0],
                        mat23_reg[2][31:0], mat23_reg[1][31:0], mat23_reg[0][31:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // ---------------- checks ----------------
    `CPR_ASSERT(a_norm_range, (v7_reg && !zero7_reg) |-> norm_or[29],
                "normalized magnitude out of range")
    `CPR_ASSERT(a_len_range, (dv_reg[0] && !dz_reg[0]) |-> (dlen_reg[0][RS-1:29] != 2'b00),
                "vector length below normalized range")
    `CPR_ASSERT(a_quo_bound, (dv_reg[QS] && !dz_reg[QS]) |-> ((dq_reg[QS][0] <= 31'h4000_0000)
                && (dq_reg[QS][1] <= 31'h4000_0000) && (dq_reg[QS][2] <= 31'h4000_0000)),
                "unit direction component above one")
    `CPR_ASSERT_RST(a_rst_empty, (!aresetn ##1 1'b1) |-> !m_tvalid,
                    "output valid right after reset")

endmodule
